>>> hdl/mmts_pkg.sv
// shared types and constants of the march c- test sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package mmts_pkg;

  // fixed widths of the request and result fields
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CHIP_W  = 2;
  localparam int unsigned FAIL_W  = 16;
  localparam int unsigned PASS_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // number of chips, highest valid chip number
  localparam int unsigned NUM_CHIPS = 3;
  localparam logic [CHIP_W-1:0] MAX_CHIP = 2'd2;

  // reset value of top_address
  localparam logic [ADDR_W-1:0] TOP_RESET = 24'd524287;

  // single set bit, shifted to the bit under test
  localparam logic [DATA_W-1:0] BIT_ONE = 8'h01;

  // saturation value of the failure counter
  localparam logic [FAIL_W-1:0] FAIL_MAX = 16'hFFFF;

  // last bit step inside a byte
  localparam logic [2:0] LAST_BIT = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CHIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ADDRESS = 2'd1;

  // request function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_ACK   = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_DONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EL_UP_W0    = 3'd0,
    EL_UP_R0W1  = 3'd1,
    EL_UP_R1W0  = 3'd2,
    EL_DN_R0W1  = 3'd3,
    EL_DN_R1W0  = 3'd4,
    EL_DN_R0    = 3'd5
  } elem_e;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] read_data;
  } in_req_t;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    elem_e             element;
    logic [CHIP_W-1:0] chip;
    logic [FAIL_W-1:0] fail_count;
    logic [PASS_W-1:0] pass_count;
  } out_rsp_t;

  // counter bank controls from the sequencer
  typedef struct packed {
    logic              en;
    logic [CHIP_W-1:0] chip;
    logic              add_fail;
    logic              add_pass;
  } tally_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/mmts_seq.sv
// next-state and next-access logic of the march c- sequence
// depends on mmts_pkg; purely combinational, registered by the top level
`default_nettype none

module mmts_seq #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  mmts_pkg::in_req_t             req_i,
  input  logic [mmts_pkg::CHIP_W-1:0]   target_chip_i,
  input  logic [mmts_pkg::ADDR_W-1:0]   top_address_i,
  input  logic                          busy_i,
  input  mmts_pkg::elem_e               elem_i,
  input  logic [ADDR_BITS-1:0]          addr_i,
  input  logic [2:0]                    bit_i,
  input  logic                          pend_i,
  input  logic [mmts_pkg::CHIP_W-1:0]   run_chip_i,
  input  logic [ADDR_BITS-1:0]          run_top_i,
  output logic                          busy_o,
  output mmts_pkg::elem_e               elem_o,
  output logic [ADDR_BITS-1:0]          addr_o,
  output logic [2:0]                    bit_o,
  output logic                          pend_o,
  output logic [mmts_pkg::CHIP_W-1:0]   run_chip_o,
  output logic [ADDR_BITS-1:0]          run_top_o,
  output mmts_pkg::op_e                 op_o,
  output logic [mmts_pkg::ADDR_W-1:0]   acc_addr_o,
  output logic [mmts_pkg::DATA_W-1:0]   wdata_o,
  output logic                          add_fail_o,
  output logic                          add_pass_o
);
  import mmts_pkg::*;

  logic [2:0]        bit_idx;
  logic [DATA_W-1:0] bit_mask;
  logic              want_one;
  logic              got_bit;
  logic              up_dir;

  // bit under test: msb first going up, lsb first going down
  always_comb begin
    up_dir   = (elem_i == EL_UP_R0W1) || (elem_i == EL_UP_R1W0);
    bit_idx  = up_dir ? (LAST_BIT - bit_i) : bit_i;
    bit_mask = BIT_ONE << bit_idx;
    want_one = (elem_i == EL_UP_R1W0) || (elem_i == EL_DN_R1W0);
    got_bit  = |(req_i.read_data & bit_mask);
  end

  // sequence step
  always_comb begin
    busy_o     = busy_i;
    elem_o     = elem_i;
    addr_o     = addr_i;
    bit_o      = bit_i;
    pend_o     = pend_i;
    run_chip_o = run_chip_i;
    run_top_o  = run_top_i;
    op_o       = OP_NONE;
    acc_addr_o = '0;
    wdata_o    = '0;
    add_fail_o = 1'b0;
    add_pass_o = 1'b0;

    if (req_i.func == FUNC_START) begin
      // start request: ignored for a chip that does not exist
      if (target_chip_i <= MAX_CHIP) begin
        run_chip_o = target_chip_i;
        run_top_o  = top_address_i[ADDR_BITS-1:0];
        busy_o     = 1'b1;
        elem_o     = EL_UP_W0;
        addr_o     = '0;
        bit_o      = '0;
        pend_o     = 1'b0;
        op_o       = OP_WRITE;
      end
    end else if (busy_i) begin
      case (elem_i)
        EL_UP_W0: begin
          if (addr_i < run_top_i) begin
            addr_o     = addr_i + 1'b1;
            op_o       = OP_WRITE;
            acc_addr_o = ADDR_W'(addr_o);
          end else begin
            elem_o = EL_UP_R0W1;
            addr_o = '0;
            bit_o  = '0;
            pend_o = 1'b1;
            op_o   = OP_READ;
          end
        end
        EL_UP_R0W1, EL_UP_R1W0, EL_DN_R0W1, EL_DN_R1W0: begin
          if (pend_i) begin
            // check the bit just read and write it back flipped
            add_fail_o = (got_bit != want_one);
            wdata_o    = want_one ? (req_i.read_data & ~bit_mask)
                                  : (req_i.read_data | bit_mask);
            pend_o     = 1'b0;
            op_o       = OP_WRITE;
            acc_addr_o = ADDR_W'(addr_i);
          end else begin
            if (bit_i < LAST_BIT) begin
              bit_o = bit_i + 1'b1;
            end else begin
              bit_o = '0;
              if (up_dir) begin
                if (addr_i < run_top_i) begin
                  addr_o = addr_i + 1'b1;
                end else begin
                  elem_o = (elem_i == EL_UP_R0W1) ? EL_UP_R1W0 : EL_DN_R0W1;
                  addr_o = (elem_i == EL_UP_R0W1) ? '0 : run_top_i;
                end
              end else begin
                if (addr_i != '0) begin
                  addr_o = addr_i - 1'b1;
                end else begin
                  elem_o = (elem_i == EL_DN_R0W1) ? EL_DN_R1W0 : EL_DN_R0;
                  addr_o = run_top_i;
                end
              end
            end
            pend_o     = 1'b1;
            op_o       = OP_READ;
            acc_addr_o = ADDR_W'(addr_o);
          end
        end
        EL_DN_R0: begin
          // final read-back: any nonzero byte counts once
          add_fail_o = (req_i.read_data != '0);
          if (addr_i != '0) begin
            addr_o     = addr_i - 1'b1;
            pend_o     = 1'b1;
            op_o       = OP_READ;
            acc_addr_o = ADDR_W'(addr_o);
          end else begin
            add_pass_o = 1'b1;
            busy_o     = 1'b0;
            pend_o     = 1'b0;
            op_o       = OP_DONE;
          end
        end
        default: begin
          busy_o = 1'b0;
          pend_o = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/mmts_tally.sv
// per-chip failure and pass counters
// depends on mmts_pkg; updated on each accepted request
`default_nettype none

module mmts_tally (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mmts_pkg::tally_ctrl_t        ctrl_i,
  output logic [mmts_pkg::FAIL_W-1:0]  fail_count_o,
  output logic [mmts_pkg::PASS_W-1:0]  pass_count_o
);
  import mmts_pkg::*;

  logic [FAIL_W-1:0] fail_q [NUM_CHIPS];
  logic [PASS_W-1:0] pass_q [NUM_CHIPS];
  logic [FAIL_W-1:0] fail_cur;
  logic [PASS_W-1:0] pass_cur;
  logic [FAIL_W-1:0] fail_d;
  logic [PASS_W-1:0] pass_d;

  // counts of the selected chip
  always_comb begin
    case (ctrl_i.chip)
      2'd0: begin
        fail_cur = fail_q[0];
        pass_cur = pass_q[0];
      end
      2'd1: begin
        fail_cur = fail_q[1];
        pass_cur = pass_q[1];
      end
      2'd2: begin
        fail_cur = fail_q[2];
        pass_cur = pass_q[2];
      end
      default: begin
        fail_cur = '0;
        pass_cur = '0;
      end
    endcase
  end

  // saturating fail count, wrapping pass count
  always_comb begin
    fail_d = (ctrl_i.add_fail && fail_cur != FAIL_MAX) ? fail_cur + 1'b1 : fail_cur;
    pass_d = ctrl_i.add_pass ? pass_cur + 1'b1 : pass_cur;
  end

  assign fail_count_o = fail_d;
  assign pass_count_o = pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHIPS; i++) begin
        fail_q[i] <= '0;
        pass_q[i] <= '0;
      end
    end else if (ctrl_i.en && ctrl_i.chip <= MAX_CHIP) begin
      fail_q[ctrl_i.chip] <= fail_d;
      pass_q[ctrl_i.chip] <= pass_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/march_memory_test_sequencer.sv
// top level of the march c- memory test sequencer
// depends on mmts_pkg, mmts_seq and mmts_tally
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-----------
//   request  | in        | in_valid_i/in_stall_o | in_req_i
//   result   | out       | out_valid_o/out_stall_i | out_rsp_o
//   config   | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//
// one request per cycle while the input is not stalled; each result appears in the cycle after its request is
// taken, from the output register fed by the sequencer logic and counter bank.
// a request is taken while the output register is empty or being emptied.
// reset clears sequence state and counters and returns configuration to its reset values at once.
`default_nettype none

module march_memory_test_sequencer #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mmts_pkg::in_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mmts_pkg::out_rsp_t               out_rsp_o,
  input  logic                             cfg_we_i,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mmts_pkg::ADDR_W-1:0]      cfg_data_i
);
  import mmts_pkg::*;

  // configuration registers
  logic [CHIP_W-1:0] target_q;
  logic [ADDR_W-1:0] top_q;

  // sequence state
  logic                 busy_q, busy_d;
  elem_e                elem_q, elem_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [2:0]           bit_q, bit_d;
  logic                 pend_q, pend_d;
  logic [CHIP_W-1:0]    run_chip_q, run_chip_d;
  logic [ADDR_BITS-1:0] run_top_q, run_top_d;

  // result path
  logic              out_valid_q, out_valid_d;
  out_rsp_t          rsp_q, rsp_d;
  logic              in_acc;
  op_e               op;
  logic [ADDR_W-1:0] acc_addr;
  logic [DATA_W-1:0] wdata;
  logic              add_fail;
  logic              add_pass;
  tally_ctrl_t       tally_ctrl;
  logic [FAIL_W-1:0] fail_count;
  logic [PASS_W-1:0] pass_count;

  // handshake
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_d = in_acc || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      top_q    <= TOP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TARGET_CHIP: target_q <= cfg_data_i[CHIP_W-1:0];
        CFG_TOP_ADDRESS: top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mmts_seq #(
    .ADDR_BITS(ADDR_BITS)
  ) u_seq (
    .req_i         (in_req_i),
    .target_chip_i (target_q),
    .top_address_i (top_q),
    .busy_i        (busy_q),
    .elem_i        (elem_q),
    .addr_i        (addr_q),
    .bit_i         (bit_q),
    .pend_i        (pend_q),
    .run_chip_i    (run_chip_q),
    .run_top_i     (run_top_q),
    .busy_o        (busy_d),
    .elem_o        (elem_d),
    .addr_o        (addr_d),
    .bit_o         (bit_d),
    .pend_o        (pend_d),
    .run_chip_o    (run_chip_d),
    .run_top_o     (run_top_d),
    .op_o          (op),
    .acc_addr_o    (acc_addr),
    .wdata_o       (wdata),
    .add_fail_o    (add_fail),
    .add_pass_o    (add_pass)
  );

  // counter bank follows the chip of the pass
  always_comb begin
    tally_ctrl.en       = in_acc;
    tally_ctrl.chip     = run_chip_d;
    tally_ctrl.add_fail = add_fail;
    tally_ctrl.add_pass = add_pass;
  end

  mmts_tally u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tally_ctrl),
    .fail_count_o (fail_count),
    .pass_count_o (pass_count)
  );

  // assemble the result
  always_comb begin
    rsp_d.op         = op;
    rsp_d.address    = acc_addr;
    rsp_d.write_data = wdata;
    rsp_d.element    = elem_d;
    rsp_d.chip       = run_chip_d;
    rsp_d.fail_count = fail_count;
    rsp_d.pass_count = pass_count;
  end

  // sequence state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      elem_q      <= EL_UP_W0;
      addr_q      <= '0;
      bit_q       <= '0;
      pend_q      <= 1'b0;
      run_chip_q  <= '0;
      run_top_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        busy_q     <= busy_d;
        elem_q     <= elem_d;
        addr_q     <= addr_d;
        bit_q      <= bit_d;
        pend_q     <= pend_d;
        run_chip_q <= run_chip_d;
        run_top_q  <= run_top_d;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mmts_checker.sv
// port-level checks of the march c- sequencer, bound to the top level
// depends on mmts_pkg and march_memory_test_sequencer
`default_nettype none

module mmts_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input mmts_pkg::out_rsp_t    out_rsp_o
);
  import mmts_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // every taken request gives a result in the next cycle
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("request taken without a result");

  // a finished pass ends in the last element with no access
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.op == OP_DONE |->
      out_rsp_o.element == EL_DN_R0 && out_rsp_o.address == '0
      && out_rsp_o.write_data == '0)
    else $error("pass finished outside the last element");

  // only a write carries data
  a_wdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.op == OP_NONE || out_rsp_o.op == OP_READ) |->
      out_rsp_o.write_data == '0)
    else $error("write data on a non-write access");

endmodule

bind march_memory_test_sequencer mmts_checker u_mmts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
